// ===== design/vlbd_pkg.sv =====
// shared types and constants for the varint length-prefixed blob deframer
package vlbd_pkg;

  localparam int DATA_W     = 8;
  localparam int KIND_W     = 2;
  localparam int LEN_W      = 32;
  // accumulator stays below 2^60: checked against 2^53 before each 7-bit shift
  localparam int ACC_W      = 60;
  localparam int LIMIT_BIT  = 53;
  localparam int PHASE_W    = 2;

  localparam logic [LEN_W-1:0] MAX_BLOB_RESET = {LEN_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TOO_LONG = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] payload_byte;
    logic              last;
  } result_t;

endpackage

// ===== design/vlbd_in_stage.sv =====
// input register stage holding one raw byte
module vlbd_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [vlbd_pkg::DATA_W-1:0] in_data_byte,
  output logic                       s1_valid,
  output logic [vlbd_pkg::DATA_W-1:0] s1_byte,
  input  logic                       s1_take
);

  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  logic [vlbd_pkg::DATA_W-1:0] s1_byte_r;
  logic                        load;

  assign in_ready = !s1_valid_r || s1_take;
  assign load     = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_byte_r <= in_data_byte;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_byte  = s1_byte_r;

endmodule

// ===== design/vlbd_parse.sv =====
// framing state, length accumulation and result decision for one byte
module vlbd_parse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [vlbd_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                        s1_valid,
  input  logic [vlbd_pkg::DATA_W-1:0] s1_byte,
  output logic                        s1_take,
  input  logic                        out_free,
  output logic                        res_load,
  output vlbd_pkg::result_t           res
);

  localparam logic [vlbd_pkg::PHASE_W-1:0] PH_LENGTH  = 2'd0;
  localparam logic [vlbd_pkg::PHASE_W-1:0] PH_PAYLOAD = 2'd1;
  localparam logic [vlbd_pkg::PHASE_W-1:0] PH_ERROR   = 2'd2;

  logic [vlbd_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [vlbd_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [vlbd_pkg::LEN_W-1:0]   rem_r, rem_nxt;
  logic [vlbd_pkg::LEN_W-1:0]   max_blob_r;
  logic [vlbd_pkg::ACC_W-1:0]   acc_sh;
  logic                         emit;
  logic                         too_long;
  logic                         rem_last;

  assign acc_sh   = {acc_r[vlbd_pkg::ACC_W-8:0], s1_byte[6:0]};
  assign too_long = (|acc_sh[vlbd_pkg::ACC_W-1:vlbd_pkg::LEN_W])
                    || (acc_sh[vlbd_pkg::LEN_W-1:0] > max_blob_r);
  assign rem_last = (rem_r <= vlbd_pkg::LEN_W'(1));

  always_comb begin
    emit             = 1'b0;
    res.kind         = vlbd_pkg::KIND_PAYLOAD;
    res.payload_byte = '0;
    res.last         = 1'b1;
    phase_nxt        = phase_r;
    acc_nxt          = acc_r;
    rem_nxt          = rem_r;
    case (phase_r)
      PH_LENGTH: begin
        if (|acc_r[vlbd_pkg::ACC_W-1:vlbd_pkg::LIMIT_BIT]) begin
          emit      = 1'b1;
          res.kind  = vlbd_pkg::KIND_OVERFLOW;
          phase_nxt = PH_ERROR;
          acc_nxt   = '0;
        end else if (s1_byte[7]) begin
          acc_nxt = acc_sh;
        end else begin
          acc_nxt = '0;
          if (too_long) begin
            emit      = 1'b1;
            res.kind  = vlbd_pkg::KIND_TOO_LONG;
            phase_nxt = PH_ERROR;
          end else if (acc_sh == '0) begin
            emit     = 1'b1;
            res.kind = vlbd_pkg::KIND_EMPTY;
          end else begin
            rem_nxt   = acc_sh[vlbd_pkg::LEN_W-1:0];
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        emit             = 1'b1;
        res.payload_byte = s1_byte;
        res.last         = rem_last;
        if (rem_last) begin
          rem_nxt   = '0;
          phase_nxt = PH_LENGTH;
        end else begin
          rem_nxt = rem_r - vlbd_pkg::LEN_W'(1);
        end
      end
      default: begin
        // error phase, and the unused code, swallow every item
        emit = 1'b0;
      end
    endcase
  end

  // an item with no result never waits on the output side
  assign s1_take  = s1_valid && (!emit || out_free);
  assign res_load = s1_take && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LENGTH;
      acc_r      <= '0;
      rem_r      <= '0;
      max_blob_r <= vlbd_pkg::MAX_BLOB_RESET;
    end else begin
      if (s1_take) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        rem_r   <= rem_nxt;
      end
      if (cfg_wr_en) begin
        max_blob_r <= cfg_wr_data;
      end
    end
  end

endmodule

// ===== design/vlbd_out_reg.sv =====
// result register driving the output channel
module vlbd_out_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        res_load,
  input  vlbd_pkg::result_t           res,
  output logic                        out_free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output vlbd_pkg::result_t           out_res
);

  logic              out_valid_r, out_valid_nxt;
  vlbd_pkg::result_t out_res_r;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== design/varint_length_prefixed_blob_deframer_core.sv =====
// top level: varint length-prefixed blob deframer, one byte per cycle unless stalled
// a byte passes the input register, then the result register, before any result
// for it appears; throughput: one byte per cycle unless a result waits on a
// stalled output; the framing state updates in the single parse stage
// reset (rst_n low, synchronous): length phase, accumulator and count cleared,
// max_blob_size back to all ones, both channels empty
module varint_length_prefixed_blob_deframer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [vlbd_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [vlbd_pkg::DATA_W-1:0] in_data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vlbd_pkg::KIND_W-1:0] out_kind,
  output logic [vlbd_pkg::DATA_W-1:0] out_payload_byte,
  output logic                        out_last
);

  logic                        s1_valid;
  logic [vlbd_pkg::DATA_W-1:0] s1_byte;
  logic                        s1_take;
  logic                        out_free;
  logic                        res_load;
  vlbd_pkg::result_t           res;
  vlbd_pkg::result_t           out_res;

  vlbd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .s1_valid     (s1_valid),
    .s1_byte      (s1_byte),
    .s1_take      (s1_take)
  );

  vlbd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s1_valid    (s1_valid),
    .s1_byte     (s1_byte),
    .s1_take     (s1_take),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res)
  );

  vlbd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_payload_byte = out_res.payload_byte;
  assign out_last         = out_res.last;

endmodule

// ===== design/vlbd_checker.sv =====
// port-level assertions for the deframer top level, with its bind
module vlbd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [vlbd_pkg::KIND_W-1:0] out_kind,
  input logic [vlbd_pkg::DATA_W-1:0] out_payload_byte,
  input logic                        out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_payload_byte) && $stable(out_last))
    else $error("stalled result changed");

  // empty blob and errors always close the frame
  a_ctrl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != vlbd_pkg::KIND_PAYLOAD |-> out_last)
    else $error("non-payload result without last");

  a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != vlbd_pkg::KIND_PAYLOAD |-> out_payload_byte == '0)
    else $error("non-payload result with nonzero byte");

  // once an error is delivered the block stays silent until reset
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_kind == vlbd_pkg::KIND_OVERFLOW
      || out_kind == vlbd_pkg::KIND_TOO_LONG) |=> !out_valid)
    else $error("result after error");

endmodule

bind varint_length_prefixed_blob_deframer_core vlbd_checker u_vlbd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_payload_byte (out_payload_byte),
  .out_last         (out_last)
);
